[design/assert_macros.svh]
// Assertion macros for the timer core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/pct_pkg.sv]
// Types, codes and reset values for the prescaled compare timer.
`timescale 1ns / 1ps

package pct_pkg;

   localparam int unsigned DATA_W     = 32;
   localparam int unsigned COUNT_W    = 64;
   localparam int unsigned PRESCALE_W = 12;
   localparam int unsigned STEP_W     = 8;
   localparam int unsigned CSR_IDX_W  = 1;

   typedef logic [1:0]            mode_type;
   typedef logic [2:0]            addr_type;
   typedef logic [DATA_W-1:0]     data_type;
   typedef logic [COUNT_W-1:0]    count_type;
   typedef logic [PRESCALE_W-1:0] prescale_type;
   typedef logic [STEP_W-1:0]     step_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;

   // item kinds
   localparam mode_type MODE_TICK  = 2'd0;
   localparam mode_type MODE_READ  = 2'd1;
   localparam mode_type MODE_WRITE = 2'd2;

   // bus register map
   localparam addr_type ADDR_CTRL     = 3'd0;
   localparam addr_type ADDR_IRQ_EN   = 3'd1;
   localparam addr_type ADDR_IRQ_STATE = 3'd2;
   localparam addr_type ADDR_IRQ_TEST = 3'd3;
   localparam addr_type ADDR_COUNT_LO = 3'd4;
   localparam addr_type ADDR_COUNT_HI = 3'd5;
   localparam addr_type ADDR_CMP_LO   = 3'd6;
   localparam addr_type ADDR_CMP_HI   = 3'd7;

   // configuration register indexes
   localparam csr_idx_type CSR_PRESCALE = 1'd0;
   localparam csr_idx_type CSR_STEP     = 1'd1;

   localparam prescale_type PRESCALE_RESET = '0;
   localparam step_type     STEP_RESET     = step_type'(1);
   localparam count_type    CMP_RESET      = '1;

endpackage

[design/prescaled_compare_timer_core.sv]
// Top level of the prescaled compare timer: 64-bit count, compare and interrupt.
`timescale 1ns / 1ps
`include "assert_macros.svh"

//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_ready | req_mode, req_reg_addr, req_write_data
//  rsp     | out       | rsp_valid / rsp_ready | rsp_read_data, rsp_irq
//  csr     | in        | csr_we                | csr_index, csr_wdata
//
//  A beat taken on req updates the timer state and lands in the rsp register
//  at the same edge; a new beat can enter every cycle while req_ready is high.
//  The path is one 64-bit add followed by one 64-bit compare.
//  req_ready drops only while a result waits and rsp_ready is low.
//  Synchronous reset clears the state to its reset values and empties rsp.

module prescaled_compare_timer_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  pct_pkg::mode_type      req_mode,
   input  pct_pkg::addr_type      req_reg_addr,
   input  pct_pkg::data_type      req_write_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output pct_pkg::data_type      rsp_read_data,
   output logic                   rsp_irq,
   input  logic                   csr_we,
   input  pct_pkg::csr_idx_type   csr_index,
   input  pct_pkg::prescale_type  csr_wdata
);

   import pct_pkg::*;

   // configuration
   prescale_type prescale_ff;
   step_type     step_ff;

   // timer state
   count_type    count_ff,       count_in;
   count_type    cmp_ff,         cmp_in;
   prescale_type pre_cnt_ff,     pre_cnt_in;
   logic         active_ff,      active_in;
   logic         irq_en_ff,      irq_en_in;
   logic         irq_latched_ff, irq_latched_in;

   // result register
   logic         rsp_valid_ff,   rsp_valid_in;
   data_type     rsp_data_ff,    rsp_data_in;
   logic         rsp_irq_ff,     rsp_irq_in;

   logic         accept;
   logic         data_bit0;

   // take a new beat whenever the result register is empty or being drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign data_bit0 = req_write_data[0];

   // configuration writes; indexes beyond the list fall through
   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff <= PRESCALE_RESET;
         step_ff     <= STEP_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PRESCALE: prescale_ff <= csr_wdata;
            CSR_STEP:     step_ff     <= csr_wdata[STEP_W-1:0];
            default:      ;
         endcase
      end
   end

   // next state and result for the beat at the input
   always_comb begin
      count_in       = count_ff;
      cmp_in         = cmp_ff;
      pre_cnt_in     = pre_cnt_ff;
      active_in      = active_ff;
      irq_en_in      = irq_en_ff;
      irq_latched_in = irq_latched_ff;
      rsp_data_in    = '0;

      case (req_mode)
         MODE_TICK: begin
            // advance only while active; wrap the prescaler on reaching its limit
            if (active_ff) begin
               if (pre_cnt_ff >= prescale_ff) begin
                  pre_cnt_in = '0;
                  count_in   = count_ff + COUNT_W'(step_ff);
               end else begin
                  pre_cnt_in = pre_cnt_ff + prescale_type'(1);
               end
            end
         end
         MODE_READ: begin
            case (req_reg_addr)
               ADDR_CTRL:      rsp_data_in = data_type'(active_ff);
               ADDR_IRQ_EN:    rsp_data_in = data_type'(irq_en_ff);
               ADDR_IRQ_STATE: rsp_data_in = data_type'(irq_latched_ff);
               ADDR_IRQ_TEST:  rsp_data_in = '0;
               ADDR_COUNT_LO:  rsp_data_in = count_ff[DATA_W-1:0];
               ADDR_COUNT_HI:  rsp_data_in = count_ff[COUNT_W-1:DATA_W];
               ADDR_CMP_LO:    rsp_data_in = cmp_ff[DATA_W-1:0];
               ADDR_CMP_HI:    rsp_data_in = cmp_ff[COUNT_W-1:DATA_W];
               default:        rsp_data_in = '0;
            endcase
         end
         MODE_WRITE: begin
            case (req_reg_addr)
               ADDR_CTRL:   active_in = data_bit0;
               ADDR_IRQ_EN: irq_en_in = data_bit0;
               ADDR_IRQ_STATE: begin
                  // write one to clear; the compare below may set it again
                  if (data_bit0) irq_latched_in = 1'b0;
               end
               ADDR_IRQ_TEST: begin
                  if (data_bit0) irq_latched_in = 1'b1;
               end
               ADDR_COUNT_LO: count_in[DATA_W-1:0]       = req_write_data;
               ADDR_COUNT_HI: count_in[COUNT_W-1:DATA_W] = req_write_data;
               ADDR_CMP_LO:   cmp_in[DATA_W-1:0]         = req_write_data;
               ADDR_CMP_HI:   cmp_in[COUNT_W-1:DATA_W]   = req_write_data;
               default:       ;
            endcase
         end
         default: ;   // unused kind: no change, reads zero
      endcase

      // latch the interrupt on the state this beat leaves behind
      if (count_in >= cmp_in) irq_latched_in = 1'b1;

      rsp_irq_in = irq_latched_in && irq_en_in;
   end

   // hold the result until taken; drop valid once drained with no new beat
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         cmp_ff         <= CMP_RESET;
         pre_cnt_ff     <= '0;
         active_ff      <= 1'b0;
         irq_en_ff      <= 1'b0;
         irq_latched_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff       <= count_in;
            cmp_ff         <= cmp_in;
            pre_cnt_ff     <= pre_cnt_in;
            active_ff      <= active_in;
            irq_en_ff      <= irq_en_in;
            irq_latched_ff <= irq_latched_in;
         end
      end
   end

   // result payload: no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
         rsp_irq_ff  <= rsp_irq_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_irq       = rsp_irq_ff;

   // checks on the timer state
   `ASSERT_IMPL(a_irq_matches_state, clock, reset, rsp_valid_ff,
      rsp_irq_ff == (irq_latched_ff && irq_en_ff), "irq out of step with state")
   `ASSERT_IMPL(a_latch_on_compare, clock, reset, rsp_valid_ff && (count_ff >= cmp_ff),
      irq_latched_ff, "count reached compare but irq not latched")
   `ASSERT_NEXT(a_idle_tick_holds, clock, reset,
      accept && (req_mode == MODE_TICK) && !active_ff,
      $stable(count_ff) && $stable(pre_cnt_ff), "inactive tick moved the counter")

endmodule
